FILE: sv/diff_drive_odometry_top_assert.svh
// Assertion macros used by the odometry top level.
`ifndef DIFF_DRIVE_ODOMETRY_TOP_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DDO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DDO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ddo_pkg.sv
// Types, constants and helper functions for the differential drive odometry block.
package ddo_pkg;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_A,
        S_MUL_B,
        S_VEL,
        S_MUL_ANG,
        S_MUL_DIST,
        S_DIV_DIST,
        S_MUL_DTH,
        S_DIV_DTH,
        S_MUL_HD,
        S_COR,
        S_MUL_DX,
        S_MUL_DY,
        S_HALF,
        S_DONE
    } t_state;

    // Configuration register indexes.
    localparam logic [1:0] REG_MPT   = 2'd0;
    localparam logic [1:0] REG_IBW   = 2'd1;
    localparam logic [1:0] REG_SWAP  = 2'd2;
    localparam logic [1:0] REG_STALE = 2'd3;

    // Outcome codes.
    localparam logic [1:0] OUT_UPDATED = 2'd0;
    localparam logic [1:0] OUT_STALE   = 2'd1;
    localparam logic [1:0] OUT_A_BAD   = 2'd2;
    localparam logic [1:0] OUT_B_BAD   = 2'd3;

    // Fixed constants of the arithmetic.
    localparam logic [30:0]        SPEED_SCALE  = 31'd125;
    localparam logic [19:0]        US_PER_S     = 20'd1000000;
    localparam logic [63:0]        US_HALF      = 64'd500000;
    localparam logic [31:0]        RAD_TO_BAM   = 32'd683565276;
    localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic [5:0]         MUL_LAST     = 6'd31;
    localparam logic [5:0]         DIV_LAST     = 6'd63;

    // Request to the serial multiply/divide unit.
    typedef struct packed {
        logic        start;
        logic        div;
        logic [33:0] a;
        logic [31:0] b;
        logic [63:0] n;
    } t_md_req;

    // Response of the serial multiply/divide unit.
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [65:0] res;
    } t_md_rsp;

    // Arctangent table in binary angle units, one entry per CORDIC step.
    function automatic logic [31:0] f_atan(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // Magnitude of a signed 32 bit value.
    function automatic logic [31:0] f_abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // Magnitude of a signed 34 bit value.
    function automatic logic [33:0] f_abs34(input logic signed [33:0] v);
        return v[33] ? 34'(-v) : 34'(v);
    endfunction

    // Apply a sign to a magnitude and clamp to the signed 32 bit range.
    function automatic logic [31:0] f_sat32(input logic [65:0] mag, input logic neg);
        logic [31:0] r;
        if (!neg) begin
            r = (mag > 66'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end else begin
            r = (mag > 66'h0_8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
        end
        return r;
    endfunction

    // Apply a sign to a magnitude and clamp to the signed 16 bit range.
    function automatic logic [15:0] f_sat16(input logic [33:0] mag, input logic neg);
        logic [15:0] r;
        if (!neg) begin
            r = (mag > 34'd32767) ? 16'h7FFF : mag[15:0];
        end else begin
            r = (mag > 34'd32768) ? 16'h8000 : (~mag[15:0] + 16'd1);
        end
        return r;
    endfunction

    // Add a signed step given as sign and magnitude, clamping to 32 bits.
    function automatic logic [31:0] f_add_sat(input logic signed [31:0] acc,
                                              input logic [35:0] mag, input logic neg);
        logic signed [37:0] d;
        logic signed [37:0] s;
        logic [31:0]        r;
        d = $signed({2'b00, mag});
        if (neg) begin
            d = -d;
        end
        s = $signed({{6{acc[31]}}, acc}) + d;
        if (s > 38'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (s < -38'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/ddo_muldiv.sv
// Bit-serial unsigned multiplier and divider by one million, shared by the sequencer.
module ddo_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ddo_pkg::t_md_req i_req,
    output ddo_pkg::t_md_rsp o_rsp
);
    import ddo_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic        r_div;
    logic [5:0]  r_cnt;
    logic [33:0] r_a;
    logic [33:0] r_hi;
    logic [31:0] r_lo;
    logic [19:0] r_rem;
    logic [63:0] r_q;

    logic [34:0] mul_sum;
    logic [20:0] div_trial;
    logic        div_ge;
    logic        last;

    // One multiplier bit or one quotient bit per cycle.
    always_comb begin
        mul_sum   = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : 35'd0);
        div_trial = {r_rem, r_q[63]};
        div_ge    = div_trial >= {1'b0, US_PER_S};
        last      = r_div ? (r_cnt == DIV_LAST) : (r_cnt == MUL_LAST);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath shift registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_div <= i_req.div;
            r_a   <= i_req.a;
            r_hi  <= 34'd0;
            r_lo  <= i_req.b;
            r_rem <= 20'd0;
            r_q   <= i_req.n;
        end else if (r_busy) begin
            if (r_div) begin
                r_rem <= div_ge ? 20'(div_trial - {1'b0, US_PER_S}) : div_trial[19:0];
                r_q   <= {r_q[62:0], div_ge};
            end else begin
                r_hi <= mul_sum[34:1];
                r_lo <= {mul_sum[0], r_lo[31:1]};
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_div ? {2'b00, r_q} : {r_hi, r_lo};

endmodule

FILE: sv/ddo_cordic.sv
// Iterative CORDIC rotator giving cosine and sine of a binary angle, one step per cycle.
module ddo_cordic #(
    parameter int STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_angle,
    output logic               o_busy,
    output logic               o_done,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);
    import ddo_pkg::*;

    localparam int CW = $clog2(STEPS);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_i;
    logic               r_flip;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [33:0] r_z;

    logic signed [33:0] z_in;
    logic signed [33:0] z0;
    logic               flip0;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] at;

    // Fold the angle into the right half plane; form the shifted terms and the step angle.
    always_comb begin
        z_in  = $signed({{2{i_angle[31]}}, i_angle});
        z0    = z_in;
        flip0 = 1'b0;
        if (z_in > 34'sd1073741824) begin
            z0    = z_in - 34'sd2147483648;
            flip0 = 1'b1;
        end else if (z_in < -34'sd1073741824) begin
            z0    = z_in + 34'sd2147483648;
            flip0 = 1'b1;
        end
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        at = $signed({2'b00, f_atan(5'(r_i))});
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Rotation registers.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= 34'sd0;
            r_z    <= z0;
            r_flip <= flip0;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule

FILE: sv/diff_drive_odometry_top.sv
// Differential drive odometry: wheel speeds to velocities, pose and heading.
//
//  word         direction  handshake            payload
//  period in    input      i_valid / o_stall    raw speeds, status, valid bits, elapsed time
//  pose out     output     o_valid / i_stall    pose, heading, velocities, half-angle terms
//  config       input      i_cfg_we             i_cfg_idx, i_cfg_data
//
// An updating period runs eight products and two divisions by one million, one at a time,
// on the bit-serial multiply/divide unit, and two CORDIC rotations.
// A skipped period runs only the half-angle rotation.
// Reset is synchronous and active low; it loads the register defaults and clears the pose.
// A new word is taken once the previous one has reached the output register, even while
// that result is still stalled downstream.
module diff_drive_odometry_top #(
    parameter int ERROR_LIMIT  = 5,
    parameter int CORDIC_STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [23:0] i_raw_speed_a,
    input  logic [7:0]         i_status_a,
    input  logic               i_valid_a,
    input  logic signed [23:0] i_raw_speed_b,
    input  logic [7:0]         i_status_b,
    input  logic               i_valid_b,
    input  logic [23:0]        i_elapsed_us,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pose_x,
    output logic signed [31:0] o_pose_y,
    output logic [31:0]        o_heading_angle,
    output logic signed [31:0] o_fwd_speed,
    output logic signed [31:0] o_yaw_rate,
    output logic signed [15:0] o_orient_sin_half,
    output logic signed [15:0] o_orient_cos_half,
    output logic [1:0]         o_outcome,
    output logic               o_restart_request
);
    import ddo_pkg::*;

    `include "diff_drive_odometry_top_assert.svh"

    t_state r_state;
    t_state n_state;

    // Configuration.
    logic [31:0] r_mpt;
    logic [23:0] r_ibw;
    logic        r_swap;
    logic [23:0] r_stale;

    // Latched input word.
    logic signed [23:0] r_raw_a;
    logic signed [23:0] r_raw_b;
    logic [7:0]         r_st_a;
    logic [7:0]         r_st_b;
    logic               r_ok_a;
    logic               r_ok_b;
    logic [23:0]        r_el;

    // Odometry state.
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic [31:0]        r_hd;
    logic [2:0]         r_err;

    // Working registers.
    logic signed [31:0] r_sa;
    logic signed [31:0] r_sb;
    logic signed [31:0] r_lin;
    logic signed [31:0] r_ang;
    logic signed [31:0] r_dist;
    logic [31:0]        r_hstep;
    logic signed [33:0] r_s;
    // The cosine sign is kept next to the sine for the x step.
    logic               r_c_neg;
    logic [15:0]        r_sh;
    logic [15:0]        r_ch;
    logic [1:0]         r_outcome;
    logic               r_restart;

    t_md_req            md_req;
    t_md_rsp            md_rsp;
    logic               cor_start;
    logic [31:0]        cor_angle;
    logic               cor_busy;
    logic               cor_done;
    logic signed [33:0] cor_cos;
    logic signed [33:0] cor_sin;

    logic               stale;
    logic               bad_a;
    logic               bad_b;
    logic               skip;
    logic [23:0]        raw_mag_a;
    logic [23:0]        raw_mag_b;
    logic [30:0]        sp_mag_a;
    logic [30:0]        sp_mag_b;
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic signed [32:0] sum33;
    logic signed [32:0] diff33;
    logic [32:0]        sum_mag;
    logic [32:0]        diff_mag;
    logic [31:0]        lin_val;
    logic [65:0]        p16;
    logic [65:0]        p30;
    logic [31:0]        dth_val;
    logic [31:0]        hstep_val;
    logic [31:0]        hd_next;
    logic [2:0]         err_inc;
    logic [33:0]        sh_mag;
    logic [33:0]        ch_mag;
    logic               out_load;

    // Checks, wheel speed magnitudes, velocity terms, rounded products and output load.
    always_comb begin
        stale     = r_el > r_stale;
        bad_a     = !r_ok_a || (r_st_a > 8'd1);
        bad_b     = !r_ok_b || (r_st_b > 8'd1);
        skip      = stale || bad_a || bad_b;
        raw_mag_a = r_raw_a[23] ? 24'(-r_raw_a) : 24'(r_raw_a);
        raw_mag_b = r_raw_b[23] ? 24'(-r_raw_b) : 24'(r_raw_b);
        sp_mag_a  = 31'(raw_mag_a) * SPEED_SCALE;
        sp_mag_b  = 31'(raw_mag_b) * SPEED_SCALE;
        left      = r_swap ? r_sa : r_sb;
        right     = r_swap ? r_sb : r_sa;
        sum33     = $signed({left[31], left}) + $signed({right[31], right});
        diff33    = $signed({right[31], right}) - $signed({left[31], left});
        sum_mag   = sum33[32] ? 33'(-sum33) : 33'(sum33);
        diff_mag  = diff33[32] ? 33'(-diff33) : 33'(diff33);
        lin_val   = f_sat32(66'((34'(sum_mag) + 34'd1) >> 1), sum33[32]);
        p16       = (md_rsp.res + 66'd32768) >> 16;
        p30       = (md_rsp.res + 66'd536870912) >> 30;
        dth_val   = f_sat32(md_rsp.res, r_ang[31]);
        // The heading step takes the sign of the turn angle.
        hstep_val = r_ang[31] ? (~p16[31:0] + 32'd1) : p16[31:0];
        hd_next   = r_hd + r_hstep;
        err_inc   = r_err + 3'd1;
        sh_mag    = (f_abs34(cor_sin) + 34'd16384) >> 15;
        ch_mag    = (f_abs34(cor_cos) + 34'd16384) >> 15;
        out_load  = (r_state == S_DONE) && (!o_valid || !i_stall);
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and unit requests.
    always_comb begin
        n_state   = r_state;
        md_req    = '0;
        cor_start = 1'b0;
        cor_angle = r_hd;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (skip) begin
                    cor_start = 1'b1;
                    cor_angle = {1'b0, r_hd[31:1]};
                    n_state   = S_HALF;
                end else begin
                    md_req.start = 1'b1;
                    md_req.a     = 34'(sp_mag_a);
                    md_req.b     = r_mpt;
                    n_state      = S_MUL_A;
                end
            end
            S_MUL_A: begin
                if (md_rsp.done) begin
                    md_req.start = 1'b1;
                    md_req.a     = 34'(sp_mag_b);
                    md_req.b     = r_mpt;
                    n_state      = S_MUL_B;
                end
            end
            S_MUL_B: begin
                if (md_rsp.done) begin
                    n_state = S_VEL;
                end
            end
            S_VEL: begin
                md_req.start = 1'b1;
                md_req.a     = {1'b0, diff_mag};
                md_req.b     = {8'd0, r_ibw};
                n_state      = S_MUL_ANG;
            end
            S_MUL_ANG: begin
                if (md_rsp.done) begin
                    md_req.start = 1'b1;
                    md_req.a     = {2'b00, f_abs32(r_lin)};
                    md_req.b     = {8'd0, r_el};
                    n_state      = S_MUL_DIST;
                end
            end
            S_MUL_DIST: begin
                if (md_rsp.done) begin
                    md_req.start = 1'b1;
                    md_req.div   = 1'b1;
                    md_req.n     = md_rsp.res[63:0] + US_HALF;
                    n_state      = S_DIV_DIST;
                end
            end
            S_DIV_DIST: begin
                if (md_rsp.done) begin
                    md_req.start = 1'b1;
                    md_req.a     = {2'b00, f_abs32(r_ang)};
                    md_req.b     = {8'd0, r_el};
                    n_state      = S_MUL_DTH;
                end
            end
            S_MUL_DTH: begin
                if (md_rsp.done) begin
                    md_req.start = 1'b1;
                    md_req.div   = 1'b1;
                    md_req.n     = md_rsp.res[63:0] + US_HALF;
                    n_state      = S_DIV_DTH;
                end
            end
            S_DIV_DTH: begin
                if (md_rsp.done) begin
                    md_req.start = 1'b1;
                    md_req.a     = {2'b00, f_abs32(dth_val)};
                    md_req.b     = RAD_TO_BAM;
                    n_state      = S_MUL_HD;
                end
            end
            S_MUL_HD: begin
                if (md_rsp.done) begin
                    cor_start = 1'b1;
                    cor_angle = r_hd;
                    n_state   = S_COR;
                end
            end
            S_COR: begin
                if (cor_done) begin
                    md_req.start = 1'b1;
                    md_req.a     = f_abs34(cor_cos);
                    md_req.b     = f_abs32(r_dist);
                    n_state      = S_MUL_DX;
                end
            end
            S_MUL_DX: begin
                if (md_rsp.done) begin
                    md_req.start = 1'b1;
                    md_req.a     = f_abs34(r_s);
                    md_req.b     = f_abs32(r_dist);
                    n_state      = S_MUL_DY;
                end
            end
            S_MUL_DY: begin
                if (md_rsp.done) begin
                    cor_start = 1'b1;
                    cor_angle = {1'b0, hd_next[31:1]};
                    n_state   = S_HALF;
                end
            end
            S_HALF: begin
                if (cor_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!o_valid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpt   <= 32'd197577;
            r_ibw   <= 24'd247322;
            r_swap  <= 1'b0;
            r_stale <= 24'd10000000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MPT:   r_mpt   <= i_cfg_data;
                REG_IBW:   r_ibw   <= i_cfg_data[23:0];
                REG_SWAP:  r_swap  <= i_cfg_data[0];
                REG_STALE: r_stale <= i_cfg_data[23:0];
                default:   r_swap  <= r_swap;
            endcase
        end
    end

    // Input word capture.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_raw_a <= i_raw_speed_a;
            r_raw_b <= i_raw_speed_b;
            r_st_a  <= i_status_a;
            r_st_b  <= i_status_b;
            r_ok_a  <= i_valid_a;
            r_ok_b  <= i_valid_b;
            r_el    <= i_elapsed_us;
        end
    end

    // Pose, heading and error count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px  <= 32'sd0;
            r_py  <= 32'sd0;
            r_hd  <= 32'd0;
            r_err <= 3'd0;
        end else begin
            if (r_state == S_CHECK && !stale && (bad_a || bad_b)) begin
                r_err <= (err_inc >= 3'(ERROR_LIMIT)) ? 3'd0 : err_inc;
            end
            if (r_state == S_MUL_DX && md_rsp.done) begin
                r_px <= f_add_sat(r_px, p30[35:0], r_dist[31] ^ r_c_neg);
            end
            if (r_state == S_MUL_DY && md_rsp.done) begin
                r_py <= f_add_sat(r_py, p30[35:0], r_dist[31] ^ r_s[33]);
                r_hd <= hd_next;
            end
        end
    end

    // Working registers and outcome.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_CHECK: begin
                r_lin     <= 32'sd0;
                r_ang     <= 32'sd0;
                r_restart <= 1'b0;
                if (stale) begin
                    r_outcome <= OUT_STALE;
                end else if (bad_a) begin
                    r_outcome <= OUT_A_BAD;
                    r_restart <= err_inc >= 3'(ERROR_LIMIT);
                end else if (bad_b) begin
                    r_outcome <= OUT_B_BAD;
                    r_restart <= err_inc >= 3'(ERROR_LIMIT);
                end else begin
                    r_outcome <= OUT_UPDATED;
                end
            end
            S_MUL_A: begin
                if (md_rsp.done) begin
                    r_sa <= f_sat32(p16, r_raw_a[23]);
                end
            end
            S_MUL_B: begin
                if (md_rsp.done) begin
                    r_sb <= f_sat32(p16, r_raw_b[23]);
                end
            end
            S_VEL: begin
                r_lin <= lin_val;
            end
            S_MUL_ANG: begin
                if (md_rsp.done) begin
                    r_ang <= f_sat32(p16, diff33[32]);
                end
            end
            S_DIV_DIST: begin
                if (md_rsp.done) begin
                    r_dist <= f_sat32(md_rsp.res, r_lin[31]);
                end
            end
            S_MUL_HD: begin
                if (md_rsp.done) begin
                    r_hstep <= hstep_val;
                end
            end
            S_COR: begin
                if (cor_done) begin
                    r_s     <= cor_sin;
                    r_c_neg <= cor_cos[33];
                end
            end
            S_HALF: begin
                if (cor_done) begin
                    r_sh <= f_sat16(sh_mag, cor_sin[33]);
                    r_ch <= f_sat16(ch_mag, cor_cos[33]);
                end
            end
            default: begin
                r_outcome <= r_outcome;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (out_load) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_pose_x           <= r_px;
            o_pose_y           <= r_py;
            o_heading_angle    <= r_hd;
            o_fwd_speed        <= r_lin;
            o_yaw_rate         <= r_ang;
            o_orient_sin_half  <= r_sh;
            o_orient_cos_half  <= r_ch;
            o_outcome          <= r_outcome;
            o_restart_request  <= r_restart;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    ddo_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_angle),
        .o_busy  (cor_busy),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    `DDO_ASSERT_NOW(a_err_range, 1'b1, r_err < 3'(ERROR_LIMIT), "error count at limit")
    `DDO_ASSERT_NOW(a_md_free, md_req.start, !md_rsp.busy, "multiplier started while busy")
    `DDO_ASSERT_NOW(a_cor_free, cor_start, !cor_busy, "rotator started while busy")
    `DDO_ASSERT_NOW(a_restart_err, o_valid && o_restart_request,
        o_outcome == OUT_A_BAD || o_outcome == OUT_B_BAD, "restart without error")
    `DDO_ASSERT_NEXT(a_skip_hold, r_state == S_CHECK && skip,
        $stable(r_px) && $stable(r_py) && $stable(r_hd), "skipped period moved pose")

endmodule

FILE: tb/odometry_checker.sv
// Watches both channels of the odometry block, predicts each result word and compares it.
module odometry_checker
    import ddo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [23:0] i_raw_speed_a,
    input  logic [7:0]         i_status_a,
    input  logic               i_valid_a,
    input  logic signed [23:0] i_raw_speed_b,
    input  logic [7:0]         i_status_b,
    input  logic               i_valid_b,
    input  logic [23:0]        i_elapsed_us,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [31:0]        i_pose_x,
    input  logic [31:0]        i_pose_y,
    input  logic [31:0]        i_heading_angle,
    input  logic [31:0]        i_fwd_speed,
    input  logic [31:0]        i_yaw_rate,
    input  logic [15:0]        i_orient_sin_half,
    input  logic [15:0]        i_orient_cos_half,
    input  logic [1:0]         i_outcome,
    input  logic               i_restart_request,
    output int                 o_fail_count,
    output int                 o_pending
);

    // One result word of the block.
    typedef struct {
        logic [31:0] pose_x;
        logic [31:0] pose_y;
        logic [31:0] heading;
        logic [31:0] lin_vel;
        logic [31:0] ang_vel;
        logic [15:0] sin_half;
        logic [15:0] cos_half;
        logic [1:0]  outcome;
        logic        restart;
    } t_pose_word;

    localparam int     FAULT_LIMIT  = 5;
    localparam int     ROTATE_STEPS = 24;
    localparam longint TICK_SCALE   = 125;
    localparam longint MICROS       = 1000000;
    localparam longint RAD_BAM      = 683565276;
    localparam longint ROT_GAIN     = 652032874;
    localparam longint MIN32        = -64'sd2147483648;
    localparam longint MAX32        = 2147483647;

    localparam longint ARC_BAM [0:31] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
        5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    // Predictor copy of configuration and state.
    logic [31:0] mpt_q;
    logic [23:0] ibw_q;
    logic        swap_q;
    logic [23:0] stale_q;
    logic [31:0] px_q;
    logic [31:0] py_q;
    logic [31:0] hd_q;
    int          faults_q;

    t_pose_word pose_words_due[$];

    // Shift right by s, rounding half away from zero.
    function automatic longint shr_round(input longint v, input int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v < 0) begin
            return -(((-v) + half) >> s);
        end
        return (v + half) >> s;
    endfunction

    function automatic longint div_round(input longint v, input longint d);
        if (v < 0) begin
            return -(((-v) + d / 2) / d);
        end
        return (v + d / 2) / d;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Rotation of the gain-corrected unit vector by a binary angle, Q2.30 result.
    task automatic rotate(input logic [31:0] angle, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint xs;
        longint ys;
        logic   flip;
        z    = longint'(angle);
        x    = ROT_GAIN;
        y    = 0;
        flip = 1'b0;
        if (z >= 64'sd2147483648) begin
            z -= 64'sd4294967296;
        end
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648;
            flip = 1'b1;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648;
            flip = 1'b1;
        end
        for (int i = 0; i < ROTATE_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= ARC_BAM[i];
            end else begin
                x += ys;
                y -= xs;
                z += ARC_BAM[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Counts a bad reading; the limit raises restart and clears the count.
    task automatic count_fault(inout t_pose_word w);
        faults_q = (faults_q + 1) & 7;
        if (faults_q >= FAULT_LIMIT) begin
            faults_q  = 0;
            w.restart = 1'b1;
        end
    endtask

    // Advances the pose for one period and returns the word the block should report.
    task automatic integrate_period(output t_pose_word w);
        longint sa, sb, left, right, lin, ang, travel, dth, c, s, hc, hs, el;
        w    = '{default: '0};
        lin  = 0;
        ang  = 0;
        el   = longint'(i_elapsed_us);
        if (i_elapsed_us > stale_q) begin
            w.outcome = OUT_STALE;
        end else if (!i_valid_a || i_status_a > 8'd1) begin
            w.outcome = OUT_A_BAD;
            count_fault(w);
        end else if (!i_valid_b || i_status_b > 8'd1) begin
            w.outcome = OUT_B_BAD;
            count_fault(w);
        end else begin
            w.outcome = OUT_UPDATED;
            sa = clamp(shr_round(longint'(i_raw_speed_a) * TICK_SCALE * longint'(mpt_q), 16),
                       MIN32, MAX32);
            sb = clamp(shr_round(longint'(i_raw_speed_b) * TICK_SCALE * longint'(mpt_q), 16),
                       MIN32, MAX32);
            left   = swap_q ? sa : sb;
            right  = swap_q ? sb : sa;
            lin    = clamp(shr_round(left + right, 1), MIN32, MAX32);
            ang    = clamp(shr_round((right - left) * longint'(ibw_q), 16), MIN32, MAX32);
            travel = clamp(div_round(lin * el, MICROS), MIN32, MAX32);
            rotate(hd_q, c, s);
            px_q = 32'(clamp(longint'($signed(px_q)) + shr_round(travel * c, 30), MIN32, MAX32));
            py_q = 32'(clamp(longint'($signed(py_q)) + shr_round(travel * s, 30), MIN32, MAX32));
            dth  = clamp(div_round(ang * el, MICROS), MIN32, MAX32);
            hd_q = hd_q + 32'(shr_round(dth * RAD_BAM, 16));
        end
        rotate(hd_q >> 1, hc, hs);
        w.pose_x   = px_q;
        w.pose_y   = py_q;
        w.heading  = hd_q;
        w.lin_vel  = 32'(lin);
        w.ang_vel  = 32'(ang);
        w.sin_half = 16'(clamp(shr_round(hs, 15), -32768, 32767));
        w.cos_half = 16'(clamp(shr_round(hc, 15), -32768, 32767));
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%08h, expected 0x%08h", $realtime, field, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Tracks configuration, compares accepted results, predicts accepted periods.
    always @(posedge i_clk) begin
        t_pose_word w;
        t_pose_word due;
        if (!i_rst_n) begin
            mpt_q    = 32'd197577;
            ibw_q    = 24'd247322;
            swap_q   = 1'b0;
            stale_q  = 24'd10000000;
            px_q     = '0;
            py_q     = '0;
            hd_q     = '0;
            faults_q = 0;
            pose_words_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MPT:   mpt_q   = i_cfg_data;
                    REG_IBW:   ibw_q   = i_cfg_data[23:0];
                    REG_SWAP:  swap_q  = i_cfg_data[0];
                    REG_STALE: stale_q = i_cfg_data[23:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pose_words_due.size() == 0) begin
                    $display("unexpected result word at %0t", $realtime);
                    o_fail_count++;
                end else begin
                    due = pose_words_due.pop_front();
                    if (i_pose_x !== due.pose_x) report_mismatch("pose_x", i_pose_x, due.pose_x);
                    if (i_pose_y !== due.pose_y) report_mismatch("pose_y", i_pose_y, due.pose_y);
                    if (i_heading_angle !== due.heading) begin
                        report_mismatch("heading", i_heading_angle, due.heading);
                    end
                    if (i_fwd_speed !== due.lin_vel) begin
                        report_mismatch("fwd_speed", i_fwd_speed, due.lin_vel);
                    end
                    if (i_yaw_rate !== due.ang_vel) begin
                        report_mismatch("yaw_rate", i_yaw_rate, due.ang_vel);
                    end
                    if (i_orient_sin_half !== due.sin_half) begin
                        report_mismatch("orient_sin_half", 32'(i_orient_sin_half),
                                        32'(due.sin_half));
                    end
                    if (i_orient_cos_half !== due.cos_half) begin
                        report_mismatch("orient_cos_half", 32'(i_orient_cos_half),
                                        32'(due.cos_half));
                    end
                    if (i_outcome !== due.outcome) begin
                        report_mismatch("outcome", 32'(i_outcome), 32'(due.outcome));
                    end
                    if (i_restart_request !== due.restart) begin
                        report_mismatch("restart_request", 32'(i_restart_request),
                                        32'(due.restart));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                integrate_period(w);
                pose_words_due.insert(pose_words_due.size(), w);
            end
        end
        o_pending = pose_words_due.size();
    end

endmodule

FILE: tb/tb_top.sv
// Top of the odometry testbench: reset, clock, stimulus, configuration phases and verdict.
module tb_top;
    import ddo_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     DRAIN_WAIT  = 700;
    localparam int     PHASE_WORDS = 250;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [31:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic signed [23:0] i_raw_speed_a;
    logic [7:0]         i_status_a;
    logic               i_valid_a;
    logic signed [23:0] i_raw_speed_b;
    logic [7:0]         i_status_b;
    logic               i_valid_b;
    logic [23:0]        i_elapsed_us;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_pose_x;
    logic signed [31:0] o_pose_y;
    logic [31:0]        o_heading_angle;
    logic signed [31:0] o_fwd_speed;
    logic signed [31:0] o_yaw_rate;
    logic signed [15:0] o_orient_sin_half;
    logic signed [15:0] o_orient_cos_half;
    logic [1:0]         o_outcome;
    logic               o_restart_request;

    int          fail_count;
    int          pending;
    longint      cycles = 0;
    int          words_sent;
    int          stall_left;
    logic        no_idle;
    logic [23:0] stale_now;

    diff_drive_odometry_top u_top (.*);

    odometry_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_raw_speed_a, .i_status_a, .i_valid_a,
        .i_raw_speed_b, .i_status_b, .i_valid_b, .i_elapsed_us,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_pose_x(o_pose_x), .i_pose_y(o_pose_y), .i_heading_angle(o_heading_angle),
        .i_fwd_speed(o_fwd_speed), .i_yaw_rate(o_yaw_rate),
        .i_orient_sin_half(o_orient_sin_half), .i_orient_cos_half(o_orient_cos_half),
        .i_outcome(o_outcome), .i_restart_request(o_restart_request),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Clock, 20 units per period; it starts low so the first rising edge sees reset.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Downstream stall pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall    <= 1'b0;
            stall_left <= idle_len();
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Offers one period word and returns at the edge that accepts it.
    task automatic send_word(input logic [23:0] ra, input logic [7:0] sa, input logic va,
                             input logic [23:0] rb, input logic [7:0] sb, input logic vb,
                             input logic [23:0] el);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_raw_speed_a <= ra;
        i_status_a    <= sa;
        i_valid_a     <= va;
        i_raw_speed_b <= rb;
        i_status_b    <= sb;
        i_valid_b     <= vb;
        i_elapsed_us  <= el;
        do begin
            @(negedge i_clk);
        end while (o_stall);
        @(posedge i_clk);
        words_sent++;
    endtask

    // Register write once every result is out and the block has settled.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_STALE) stale_now = data[23:0];
    endtask

    function automatic logic [23:0] pick_speed();
        if ($urandom_range(0, 9) == 0) return 24'($urandom);
        return 24'($urandom_range(0, 8000)) - 24'd4000;
    endfunction

    // One random period: mostly good readings, some faults, stale and raw noise.
    task automatic send_random();
        int          kind;
        logic [23:0] lim;
        logic [23:0] el;
        kind = $urandom_range(0, 99);
        lim  = (stale_now < 24'd200000) ? stale_now : 24'd200000;
        el   = ($urandom_range(0, 19) == 0) ? 24'($urandom_range(0, stale_now))
                                            : 24'($urandom_range(0, lim));
        if (kind < 75) begin
            send_word(pick_speed(), 8'($urandom_range(0, 1)), 1'b1,
                      pick_speed(), 8'($urandom_range(0, 1)), 1'b1, el);
        end else if (kind < 80) begin
            send_word(pick_speed(), 8'($urandom), 1'($urandom),
                      pick_speed(), 8'($urandom_range(0, 1)), 1'b1, el);
        end else if (kind < 85) begin
            send_word(pick_speed(), 8'($urandom_range(0, 1)), 1'b1,
                      pick_speed(), 8'($urandom), 1'($urandom), el);
        end else if (kind < 90 && stale_now != 24'hFFFFFF) begin
            send_word(pick_speed(), 8'($urandom), 1'($urandom), pick_speed(), 8'($urandom),
                      1'($urandom), 24'($urandom_range(stale_now + 1, 24'hFFFFFF)));
        end else begin
            send_word(24'($urandom), 8'($urandom), 1'($urandom),
                      24'($urandom), 8'($urandom), 1'($urandom), 24'($urandom));
        end
    endtask

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++) begin
            no_idle = (n < 40);
            send_random();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_MPT;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_raw_speed_a <= '0;
        i_status_a    <= '0;
        i_valid_a     <= 1'b0;
        i_raw_speed_b <= '0;
        i_status_b    <= '0;
        i_valid_b     <= 1'b0;
        i_elapsed_us  <= '0;
        words_sent    = 0;
        no_idle       = 1'b0;
        stale_now     = 24'd10000000;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed periods at reset settings.
        send_word(24'd0, 8'd0, 1'b1, 24'd0, 8'd0, 1'b1, 24'd0);
        send_word(24'd1000, 8'd1, 1'b1, 24'd1000, 8'd0, 1'b1, 24'd100000);
        send_word(24'd3000, 8'd0, 1'b1, -24'sd3000, 8'd0, 1'b1, 24'd500000);
        send_word(24'h7FFFFF, 8'd0, 1'b1, 24'h800000, 8'd1, 1'b1, 24'd10000000);
        send_word(24'h800000, 8'd0, 1'b1, 24'h7FFFFF, 8'd0, 1'b1, 24'd10000000);
        send_word(24'h7FFFFF, 8'd0, 1'b1, 24'h7FFFFF, 8'd0, 1'b1, 24'd10000000);
        send_word(24'h800000, 8'd1, 1'b1, 24'h800000, 8'd1, 1'b1, 24'd10000000);
        // Stale period just over the limit, with bad readings that must not count.
        send_word(24'd5, 8'hFF, 1'b0, 24'd5, 8'hFF, 1'b0, 24'd10000001);
        send_word(24'd5, 8'd0, 1'b1, 24'd5, 8'd0, 1'b1, 24'hFFFFFF);
        // Five faults in a row raise restart; motor A wins when both are bad.
        send_word(24'd10, 8'd2, 1'b1, 24'd10, 8'd0, 1'b1, 24'd1000);
        send_word(24'd10, 8'd0, 1'b0, 24'd10, 8'd0, 1'b1, 24'd1000);
        send_word(24'd10, 8'd0, 1'b1, 24'd10, 8'hFF, 1'b1, 24'd1000);
        send_word(24'd10, 8'd0, 1'b1, 24'd10, 8'd0, 1'b0, 24'd1000);
        send_word(24'd10, 8'hFF, 1'b0, 24'd10, 8'hFF, 1'b0, 24'd1000);
        send_word(24'd10, 8'd0, 1'b1, 24'd10, 8'd7, 1'b1, 24'd1000);
        // Hard turns to wrap the heading several times.
        for (int k = 0; k < 6; k++) begin
            send_word(24'd40000, 8'd0, 1'b1, -24'sd40000, 8'd0, 1'b1, 24'd2000000);
        end

        random_phase(PHASE_WORDS);

        // Extreme settings: widest scale, no turning, swapped sides, no stale cutoff.
        write_reg(REG_MPT, 32'hFFFF_FFFF);
        write_reg(REG_IBW, 32'd0);
        write_reg(REG_SWAP, 32'd1);
        write_reg(REG_STALE, 32'h00FF_FFFF);
        random_phase(PHASE_WORDS);

        // Opposite extremes: zero scale, widest turn factor, everything but zero time stale.
        write_reg(REG_MPT, 32'd0);
        write_reg(REG_IBW, 32'h00FF_FFFF);
        write_reg(REG_SWAP, 32'd0);
        write_reg(REG_STALE, 32'd0);
        random_phase(PHASE_WORDS / 2);

        // Random moderate geometry.
        write_reg(REG_MPT, 32'($urandom_range(1000, 4000000)));
        write_reg(REG_IBW, 32'($urandom_range(10000, 2000000)));
        write_reg(REG_SWAP, 32'($urandom_range(0, 1)));
        write_reg(REG_STALE, 32'($urandom_range(50000, 300000)));
        random_phase(PHASE_WORDS);

        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d period words over four register settings, including extremes,",
                 words_sent);
        $display("with fault runs, stale periods and random stalls on both channels.");
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/ddo_pkg.sv
sv/ddo_muldiv.sv
sv/ddo_cordic.sv
sv/diff_drive_odometry_top.sv
tb/odometry_checker.sv
tb/tb_top.sv
